// ===== rtl/ktbl_pkg.sv =====
// shared types and constants for the keyed table
// holds table capacity, entry layout, cell control struct, status and state codes
// no dependencies
package ktbl_pkg;

	localparam int CAPACITY    = 16;
	localparam int CNT_W       = $clog2(CAPACITY + 1);
	localparam int KEY_W       = 64;
	localparam int VAL_W       = 64;
	localparam int COUNT_OUT_W = 5;

	// one table entry: two key halves and a value
	typedef struct packed {
		logic [KEY_W-1:0] key_high;
		logic [KEY_W-1:0] key_low;
		logic [VAL_W-1:0] value;
	} entry_t;

	// per-cell control from the sequencer
	typedef struct packed {
		logic occupied;
		logic append;
		logic modify;
		logic remove;
	} cell_ctl_t;

	typedef enum logic [1:0] {
		ST_SUCCESS   = 2'd0,
		ST_INVALID   = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_NO_ROOM   = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_CMP  = 3'b010,
		S_UPD  = 3'b100
	} state_t;

endpackage

// ===== rtl/ktbl_cell.sv =====
// one slot of the keyed table chain
// holds an entry, compares it against the request and takes its neighbor on delete
// depends on ktbl_pkg
module ktbl_cell
	import ktbl_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cell_ctl_t ctl,
	input  entry_t    req,
	input  entry_t    next_entry,
	input  logic      seen_in,
	output entry_t    cur_entry,
	output logic      seen_out,
	output logic      hit
);

	entry_t entry_q;
	logic   match_q;

	// key compare, registered for the update cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else begin
			match_q <= ctl.occupied && (entry_q.key_high == req.key_high)
				&& (entry_q.key_low == req.key_low);
		end
	end

	// hit flag travels down the chain: set at and after the matching cell
	assign seen_out = seen_in | match_q;

	// entry update: shift down on delete, rewrite value on modify, load on append
	always_ff @(posedge clk) begin
		if (ctl.remove && seen_out) begin
			entry_q <= next_entry;
		end else if (ctl.modify && match_q) begin
			entry_q.value <= req.value;
		end else if (ctl.append) begin
			entry_q <= req;
		end
	end

	assign cur_entry = entry_q;
	assign hit       = match_q;

endmodule

// ===== rtl/keyed_table_install_modify_delete.sv =====
// keyed table with install, modify and delete of 128-bit keys
//
// input channel: in_valid / in_stall carry one request beat: key_present,
// key_high, key_low, value_present, entry_value. output channel:
// out_valid / out_stall carry one result beat per request: status and
// entry_count (occupied entries after the request).
// the table is a chain of CAPACITY cells kept packed from slot 0. a request
// goes through capture, a parallel key compare in every cell, then
// the update, where a delete moves every cell after the hit down by one in
// the same cycle. the result is registered at the update step, and a new
// request is taken only once the sequencer is back in idle, so requests do
// not overlap, paced by the compare and update steps of the sequencer.
// in_stall is high while a request is in flight. if the receiver stalls,
// the result sits in the output register and the next request proceeds up
// to its update step, where it waits until the output register is taken.
// reset clears the entry count, the result valid flag and the sequencer; entry
// contents are not cleared, since only slots below the count are ever compared.
// depends on ktbl_pkg and ktbl_cell
module keyed_table_install_modify_delete
	import ktbl_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   key_present,
	input  logic [KEY_W-1:0]       key_high,
	input  logic [KEY_W-1:0]       key_low,
	input  logic                   value_present,
	input  logic [VAL_W-1:0]       entry_value,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [1:0]             status,
	output logic [COUNT_OUT_W-1:0] entry_count
);

	state_t                 state_q;
	entry_t                 req_q;
	logic                   key_present_q;
	logic                   value_present_q;
	logic [CNT_W-1:0]       count_q;
	logic                   out_valid_q;
	status_t                out_status_q;
	logic [COUNT_OUT_W-1:0] out_count_q;

	entry_t                 cell_entry [CAPACITY];
	logic   [CAPACITY:0]    seen;
	logic   [CAPACITY-1:0]  hit_vec;

	logic    go;
	logic    hit_any;
	logic    full;
	logic    do_modify;
	logic    do_remove;
	logic    do_append;
	status_t res_status;
	logic [CNT_W-1:0] res_count;

	assign in_stall = (state_q != S_IDLE);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_valid) state_q <= S_CMP;
				S_CMP:  state_q <= S_UPD;
				S_UPD:  if (go) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			req_q.key_high  <= key_high;
			req_q.key_low   <= key_low;
			req_q.value     <= entry_value;
			key_present_q   <= key_present;
			value_present_q <= value_present;
		end
	end

	// update decision
	assign go       = (state_q == S_UPD) && !(out_valid_q && out_stall);
	assign hit_any  = seen[CAPACITY];
	assign full     = (count_q >= CNT_W'(CAPACITY));
	assign do_modify = go && key_present_q && hit_any && value_present_q;
	assign do_remove = go && key_present_q && hit_any && !value_present_q;
	assign do_append = go && key_present_q && !hit_any && value_present_q && !full;

	always_comb begin
		res_count = count_q;
		priority if (!key_present_q) begin
			res_status = ST_INVALID;
		end else if (hit_any && value_present_q) begin
			res_status = ST_SUCCESS;
		end else if (hit_any) begin
			res_status = ST_SUCCESS;
			res_count  = count_q - CNT_W'(1);
		end else if (!value_present_q) begin
			res_status = ST_NOT_FOUND;
		end else if (full) begin
			res_status = ST_NO_ROOM;
		end else begin
			res_status = ST_SUCCESS;
			res_count  = count_q + CNT_W'(1);
		end
	end

	// cell chain
	assign seen[0] = 1'b0;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		cell_ctl_t ctl;
		entry_t    nbr;

		assign ctl.occupied = (CNT_W'(i) < count_q);
		assign ctl.append   = do_append && (count_q == CNT_W'(i));
		assign ctl.modify   = do_modify;
		assign ctl.remove   = do_remove;

		if (i == CAPACITY - 1) begin : g_last
			assign nbr = '0;
		end else begin : g_mid
			assign nbr = cell_entry[i+1];
		end

		ktbl_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.req        (req_q),
			.next_entry (nbr),
			.seen_in    (seen[i]),
			.cur_entry  (cell_entry[i]),
			.seen_out   (seen[i+1]),
			.hit        (hit_vec[i])
		);
	end

	// entry count and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (go) begin
				count_q     <= res_count;
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			out_status_q <= res_status;
			out_count_q  <= COUNT_OUT_W'(res_count);
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = out_status_q;
	assign entry_count = out_count_q;

`ifndef NO_ASSERTIONS
	// count never exceeds the table size
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	// keys are unique, so at most one cell hits during update
	a_single_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UPD) |-> $onehot0(hit_vec))
		else $error("more than one cell matched");

	// a shown result always reports the current count
	a_out_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_count_q == COUNT_OUT_W'(count_q)))
		else $error("result count differs from table count");

	// a delete drops exactly one entry
	a_remove_count: assert property (@(posedge clk) disable iff (!arst_n)
		do_remove |=> (count_q == $past(count_q) - CNT_W'(1)))
		else $error("delete did not drop one entry");
`endif

endmodule

// ===== dv/tb_top.sv =====
// testbench for the keyed table: install, modify, delete, full and null-key requests
// predicts status and entry count per request beat and checks every result beat in order
// depends on ktbl_pkg and keyed_table_install_modify_delete
`timescale 1ns / 1ps

module tb_top;
	import ktbl_pkg::*;

	localparam int CLK_HALF    = 4;
	localparam int CYCLE_LIMIT = 200000;
	localparam int POOL_SIZE   = 20;
	localparam int MAX_GAP     = 13;
	localparam int DRAIN_WAIT  = 10;

	typedef struct {
		status_t                status;
		logic [COUNT_OUT_W-1:0] count;
	} table_reply_t;

	logic                   clk;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_stall;
	logic                   key_present;
	logic [KEY_W-1:0]       key_high;
	logic [KEY_W-1:0]       key_low;
	logic                   value_present;
	logic [VAL_W-1:0]       entry_value;
	logic                   out_valid;
	logic                   out_stall;
	logic [1:0]             status;
	logic [COUNT_OUT_W-1:0] entry_count;

	// shadow copy of the table
	logic [KEY_W-1:0] shadow_key_hi [CAPACITY];
	logic [KEY_W-1:0] shadow_key_lo [CAPACITY];
	logic [VAL_W-1:0] shadow_val    [CAPACITY];
	int               shadow_count;

	// keys reused by the random traffic so that hits and a full table happen
	logic [KEY_W-1:0] pool_hi [POOL_SIZE];
	logic [KEY_W-1:0] pool_lo [POOL_SIZE];

	table_reply_t pending_replies[$];
	int           err_count;
	int           beats_sent;
	int           beats_checked;
	int           status_seen [4];
	int           peak_count;
	int           cycle_count;
	logic         no_idle;
	int           out_hold;

	keyed_table_install_modify_delete u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.key_present  (key_present),
		.key_high     (key_high),
		.key_low      (key_low),
		.value_present(value_present),
		.entry_value  (entry_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.entry_count  (entry_count)
	);

	// clock
	initial clk = 1'b0;
	always #CLK_HALF clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic int draw_gap();
		if (no_idle)
			return 0;
		return $urandom_range(0, MAX_GAP);
	endfunction

	// update the shadow table with one request and give the reply it causes
	function automatic table_reply_t apply_request(logic kp, logic [KEY_W-1:0] kh,
			logic [KEY_W-1:0] kl, logic vp, logic [VAL_W-1:0] v);
		table_reply_t r;
		int           hit;
		int           i;
		r.status = ST_SUCCESS;
		hit = -1;
		if (!kp) begin
			r.status = ST_INVALID;
		end else begin
			for (i = 0; i < shadow_count; i++)
				if (hit < 0 && shadow_key_hi[i] == kh && shadow_key_lo[i] == kl)
					hit = i;
			if (hit >= 0 && vp) begin
				shadow_val[hit] = v;
			end else if (hit >= 0) begin
				// delete: close the gap to keep the table packed
				for (i = hit; i + 1 < shadow_count; i++) begin
					shadow_key_hi[i] = shadow_key_hi[i + 1];
					shadow_key_lo[i] = shadow_key_lo[i + 1];
					shadow_val[i]    = shadow_val[i + 1];
				end
				shadow_count--;
			end else if (!vp) begin
				r.status = ST_NOT_FOUND;
			end else if (shadow_count >= CAPACITY) begin
				r.status = ST_NO_ROOM;
			end else begin
				shadow_key_hi[shadow_count] = kh;
				shadow_key_lo[shadow_count] = kl;
				shadow_val[shadow_count]    = v;
				shadow_count++;
			end
		end
		r.count = COUNT_OUT_W'(shadow_count);
		return r;
	endfunction

	// send one request beat; valid stays high afterwards for a back-to-back beat
	task automatic send_request(logic kp, logic [KEY_W-1:0] kh, logic [KEY_W-1:0] kl,
			logic vp, logic [VAL_W-1:0] v);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid      <= 1'b1;
		key_present   <= kp;
		key_high      <= kh;
		key_low       <= kl;
		value_present <= vp;
		entry_value   <= v;
		do
			@(posedge clk);
		while (in_stall);
		pending_replies.push_back(apply_request(kp, kh, kl, vp, v));
		beats_sent++;
	endtask

	// result side: random stall per beat, in-order compare
	initial begin
		table_reply_t want;
		logic         bad;
		out_stall <= 1'b0;
		out_hold = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				beats_checked++;
				status_seen[status]++;
				if (entry_count > peak_count)
					peak_count = entry_count;
				if (pending_replies.size() == 0) begin
					err_count++;
					if (err_count <= 10)
						$display("result beat with nothing expected: status %0d count %0d",
							status, entry_count);
				end else begin
					want = pending_replies.pop_front();
					bad = 1'b0;
					if (status !== want.status)
						bad = 1'b1;
					if (entry_count !== want.count)
						bad = 1'b1;
					if (bad) begin
						err_count++;
						if (err_count <= 10)
							$display("mismatch on beat %0d: status exp %0d got %0d, count exp %0d got %0d",
								beats_checked, want.status, status, want.count, entry_count);
					end
				end
				out_hold = draw_gap();
			end else if (out_hold > 0) begin
				out_hold--;
			end
			out_stall <= (out_hold > 0);
		end
	end

	// null key with and without a value, extreme key halves
	task automatic test_null_key();
		send_request(1'b0, '1, '1, 1'b1, '1);
		send_request(1'b0, '0, '0, 1'b0, '0);
	endtask

	// append, modify, delete of a missing key, delete of the first entry
	task automatic test_basic_ops();
		send_request(1'b1, pool_hi[0], pool_lo[0], 1'b1, '0);
		send_request(1'b1, pool_hi[1], pool_lo[1], 1'b1, '1);
		send_request(1'b1, pool_hi[2], pool_lo[2], 1'b1, rand64());
		send_request(1'b1, pool_hi[1], pool_lo[1], 1'b1, rand64());
		send_request(1'b1, pool_hi[3], pool_lo[3], 1'b0, rand64());
		send_request(1'b1, pool_hi[0], pool_lo[0], 1'b0, '0);
	endtask

	// keys that match in one half only must miss
	task automatic test_partial_key_match();
		send_request(1'b1, pool_hi[1], pool_lo[0], 1'b0, '0);
		send_request(1'b1, pool_hi[2], ~pool_lo[2], 1'b0, '1);
	endtask

	// fill the table, overflow it, then modify and delete while full
	task automatic test_full_table();
		int k;
		for (k = 3; shadow_count < CAPACITY; k++)
			send_request(1'b1, pool_hi[k], pool_lo[k], 1'b1, rand64());
		send_request(1'b1, pool_hi[POOL_SIZE-1], ~pool_lo[POOL_SIZE-1], 1'b1, rand64());
		send_request(1'b1, pool_hi[5], pool_lo[5], 1'b1, '1);
		send_request(1'b1, shadow_key_hi[CAPACITY-1], shadow_key_lo[CAPACITY-1], 1'b0, '0);
	endtask

	// mostly pool keys with random content, some null and unknown keys
	task automatic test_random_traffic();
		int               seg;
		int               vp_pct;
		int               pick;
		int               idx;
		logic             kp;
		logic [KEY_W-1:0] kh;
		logic [KEY_W-1:0] kl;
		for (seg = 0; seg < 13; seg++) begin
			case (seg % 3)
				0: vp_pct = 85;
				1: vp_pct = 55;
				default: vp_pct = 25;
			endcase
			no_idle = (seg % 4 == 3);
			repeat (50) begin
				pick = $urandom_range(0, 99);
				idx  = $urandom_range(0, POOL_SIZE - 1);
				kp   = 1'b1;
				kh   = pool_hi[idx];
				kl   = pool_lo[idx];
				if (pick < 8) begin
					kp = 1'b0;
				end else if (pick < 16) begin
					kh = rand64();
					kl = rand64();
				end
				send_request(kp, kh, kl, ($urandom_range(0, 99) < vp_pct), rand64());
			end
		end
		no_idle = 1'b0;
	endtask

	// main sequence
	initial begin
		int i;
		arst_n        <= 1'b0;
		in_valid      <= 1'b0;
		key_present   <= 1'b0;
		key_high      <= '0;
		key_low       <= '0;
		value_present <= 1'b0;
		entry_value   <= '0;
		err_count     = 0;
		beats_sent    = 0;
		beats_checked = 0;
		peak_count    = 0;
		cycle_count   = 0;
		shadow_count  = 0;
		no_idle       = 1'b0;
		for (i = 0; i < 4; i++)
			status_seen[i] = 0;
		pool_hi[0] = '0;
		pool_lo[0] = '0;
		pool_hi[1] = '1;
		pool_lo[1] = '1;
		for (i = 2; i < POOL_SIZE; i++) begin
			pool_hi[i] = rand64();
			pool_lo[i] = rand64();
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_null_key();
		test_basic_ops();
		test_partial_key_match();
		test_full_table();
		test_random_traffic();
		in_valid <= 1'b0;

		// drain
		while (pending_replies.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (pending_replies.size() != 0)
			err_count++;

		$display("sent %0d request beats, checked %0d result beats, %0d mismatches",
			beats_sent, beats_checked, err_count);
		$display("status counts ok/invalid/not-found/full: %0d/%0d/%0d/%0d, peak count %0d",
			status_seen[0], status_seen[1], status_seen[2], status_seen[3], peak_count);
		if (err_count == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule
